// File: src/tlbpat_pkg.sv
// Shared constants, result kinds and controller/datapath interface structs
// for the paged address translator. No dependencies.
`default_nettype none

package tlbpat_pkg;

    // Address split: page number above, byte offset below
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned OFFSET_W    = 8;
    localparam int unsigned PAGE_W      = ADDR_W - OFFSET_W;
    localparam int unsigned FRAME_W     = 8;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PAGE_COUNT  = 1 << PAGE_W;
    localparam int unsigned FRAME_COUNT = 1 << FRAME_W;
    localparam int unsigned MEM_ADDR_W  = FRAME_W + OFFSET_W;
    localparam int unsigned MEM_DEPTH   = 1 << MEM_ADDR_W;

    // TLB geometry
    localparam int unsigned TLB_ENTRIES = 16;
    localparam int unsigned TLB_IDX_W   = $clog2(TLB_ENTRIES);

    localparam int unsigned COUNT_W = 16;

    // Stream payload widths
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned IN_USER_W  = 1;
    localparam int unsigned OUT_FIELD_W = BYTE_W + PAGE_W + FRAME_W + 3 + 2 * COUNT_W;
    localparam int unsigned OUT_DATA_W = 64;
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_FIELD_W;
    localparam int unsigned OUT_USER_W = 2;

    // Input request opcodes
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_FILL      = 1'b1;

    typedef enum logic [OUT_USER_W-1:0] {
        KIND_VALUE = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;   // capture request, start page-table read
        logic do_hit;      // TLB hit: count, read frame memory
        logic do_table;    // table hit: refill TLB, read frame memory
        logic do_fault;    // allocate frame, emit fill request
        logic fill_write;  // store one fill byte
        logic fill_read;   // read the byte of the pending access
        logic emit_value;  // load output with the memory byte
        logic emit_error;  // load output with an error result
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op;
        logic pending;
        logic tlb_hit;
        logic pt_valid;
        logic fill_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: src/tlbpat_ctrl.sv
// Sequencing state machine of the paged address translator.
// Depends on tlbpat_pkg for the command and status structs.
`default_nettype none

module tlbpat_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire tlbpat_pkg::dp_status_t status,
    output tlbpat_pkg::dp_cmd_t        cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_FILLRD,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   order_error;

    assign s_axis_tready = (state_reg == S_IDLE);

    // Translate while filling, or fill with nothing pending
    assign order_error = (status.op == tlbpat_pkg::OP_TRANSLATE) ? status.pending
                                                                  : !status.pending;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                priority if (order_error)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit_error = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (status.op == tlbpat_pkg::OP_FILL)
                begin
                    cmd.fill_write = 1'b1;
                    state_next     = status.fill_last ? S_FILLRD : S_IDLE;
                end
                else if (status.tlb_hit)
                begin
                    cmd.do_hit = 1'b1;
                    state_next = S_READ;
                end
                else if (status.pt_valid)
                begin
                    cmd.do_table = 1'b1;
                    state_next   = S_READ;
                end
                else
                begin
                    // hold the fault until the output register can take it
                    if (status.out_free)
                    begin
                        cmd.do_fault = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_FILLRD:
            begin
                cmd.fill_read = 1'b1;
                state_next    = S_READ;
            end
            S_READ:
            begin
                if (status.out_free)
                begin
                    cmd.emit_value = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/tlbpat_dp.sv
// Datapath of the paged address translator: TLB, page table, frame memory,
// counters, fill tracking and output register. Depends on tlbpat_pkg.
`default_nettype none

module tlbpat_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [tlbpat_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  wire logic [tlbpat_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [tlbpat_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    output logic [tlbpat_pkg::OUT_USER_W-1:0]          m_axis_tuser,
    input  wire tlbpat_pkg::dp_cmd_t                   cmd,
    output tlbpat_pkg::dp_status_t                     status
);

    // Captured request
    logic                              item_op_reg;
    logic [tlbpat_pkg::ADDR_W-1:0]     item_addr_reg;
    logic [tlbpat_pkg::BYTE_W-1:0]     item_byte_reg;
    logic [tlbpat_pkg::PAGE_W-1:0]     page;
    logic [tlbpat_pkg::OFFSET_W-1:0]   offset;
    logic [tlbpat_pkg::PAGE_W-1:0]     in_page;

    // Page table
    logic [tlbpat_pkg::PAGE_COUNT-1:0] pt_valid_reg;
    logic [tlbpat_pkg::FRAME_W-1:0]    pt_mem [tlbpat_pkg::PAGE_COUNT];
    logic [tlbpat_pkg::FRAME_W-1:0]    pt_data_reg;

    // TLB
    logic [tlbpat_pkg::TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [tlbpat_pkg::PAGE_W-1:0]      tlb_tag_reg   [tlbpat_pkg::TLB_ENTRIES];
    logic [tlbpat_pkg::FRAME_W-1:0]     tlb_frame_reg [tlbpat_pkg::TLB_ENTRIES];
    logic [tlbpat_pkg::TLB_IDX_W-1:0]   tlb_ptr_reg;
    logic [tlbpat_pkg::TLB_ENTRIES-1:0] tlb_match;
    logic [tlbpat_pkg::FRAME_W-1:0]     hit_frame;
    logic                               tlb_insert;

    // Frame memory
    logic [tlbpat_pkg::BYTE_W-1:0]      fm_mem [tlbpat_pkg::MEM_DEPTH];
    logic [tlbpat_pkg::BYTE_W-1:0]      fm_data_reg;
    logic                               fm_rd_en;
    logic [tlbpat_pkg::MEM_ADDR_W-1:0]  fm_rd_addr;

    // Allocation, counters and fill tracking
    logic [tlbpat_pkg::FRAME_W-1:0]     free_frame_reg;
    logic [tlbpat_pkg::COUNT_W-1:0]     hit_cnt_reg;
    logic [tlbpat_pkg::COUNT_W-1:0]     fault_cnt_reg;
    logic [tlbpat_pkg::COUNT_W-1:0]     fault_cnt_next;
    logic                               pending_reg;
    logic [tlbpat_pkg::OFFSET_W-1:0]    fill_pos_reg;
    logic [tlbpat_pkg::ADDR_W-1:0]      pend_addr_reg;
    logic [tlbpat_pkg::FRAME_W-1:0]     pend_frame_reg;
    logic                               fill_last;

    logic [tlbpat_pkg::FRAME_W-1:0]     sel_frame;

    // Result details held across the memory read
    logic [tlbpat_pkg::PAGE_W-1:0]      res_page_reg;
    logic [tlbpat_pkg::FRAME_W-1:0]     res_frame_reg;
    logic                               res_tlb_reg;
    logic                               res_tbl_reg;
    logic                               res_pf_reg;

    // Output register
    logic                               out_valid_reg;
    logic                               out_load;
    tlbpat_pkg::kind_t                  out_kind_reg;
    logic [tlbpat_pkg::BYTE_W-1:0]      out_value_reg;
    logic [tlbpat_pkg::PAGE_W-1:0]      out_page_reg;
    logic [tlbpat_pkg::FRAME_W-1:0]     out_frame_reg;
    logic                               out_tlb_reg;
    logic                               out_tbl_reg;
    logic                               out_pf_reg;
    logic [tlbpat_pkg::COUNT_W-1:0]     out_hits_reg;
    logic [tlbpat_pkg::COUNT_W-1:0]     out_faults_reg;

    assign in_page = s_axis_tdata[tlbpat_pkg::ADDR_W-1:tlbpat_pkg::OFFSET_W];
    assign page    = item_addr_reg[tlbpat_pkg::ADDR_W-1:tlbpat_pkg::OFFSET_W];
    assign offset  = item_addr_reg[tlbpat_pkg::OFFSET_W-1:0];

    // Parallel tag compare, lowest matching entry wins
    always_comb
    begin
        hit_frame = '0;
        for (int i = 0; i < tlbpat_pkg::TLB_ENTRIES; i++)
        begin
            tlb_match[i] = tlb_valid_reg[i] && (tlb_tag_reg[i] == page);
        end
        for (int i = tlbpat_pkg::TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_match[i])
            begin
                hit_frame = tlb_frame_reg[i];
            end
        end
    end

    assign fill_last  = (fill_pos_reg == {tlbpat_pkg::OFFSET_W{1'b1}});
    assign sel_frame  = cmd.do_fault ? free_frame_reg
                      : (cmd.do_hit ? hit_frame : pt_data_reg);
    assign tlb_insert = cmd.do_table || cmd.do_fault;

    assign fault_cnt_next = (fault_cnt_reg == {tlbpat_pkg::COUNT_W{1'b1}})
                          ? fault_cnt_reg : fault_cnt_reg + 1'b1;

    assign fm_rd_en   = cmd.do_hit || cmd.do_table || cmd.fill_read;
    assign fm_rd_addr = cmd.fill_read
                      ? {pend_frame_reg, pend_addr_reg[tlbpat_pkg::OFFSET_W-1:0]}
                      : {sel_frame, offset};

    assign out_load = cmd.emit_value || cmd.emit_error || cmd.do_fault;

    assign status.op        = item_op_reg;
    assign status.pending   = pending_reg;
    assign status.tlb_hit   = |tlb_match;
    assign status.pt_valid  = pt_valid_reg[page];
    assign status.fill_last = fill_last;
    assign status.out_free  = !out_valid_reg || m_axis_tready;

    // Request capture and result details
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_op_reg   <= s_axis_tuser[0];
            item_addr_reg <= s_axis_tdata[tlbpat_pkg::ADDR_W-1:0];
            item_byte_reg <= s_axis_tdata[tlbpat_pkg::ADDR_W +: tlbpat_pkg::BYTE_W];
        end
        if (cmd.do_hit || cmd.do_table)
        begin
            res_page_reg  <= page;
            res_frame_reg <= sel_frame;
            res_tlb_reg   <= cmd.do_hit;
            res_tbl_reg   <= cmd.do_table;
            res_pf_reg    <= 1'b0;
        end
        else if (cmd.fill_write && fill_last)
        begin
            res_page_reg  <= pend_addr_reg[tlbpat_pkg::ADDR_W-1:tlbpat_pkg::OFFSET_W];
            res_frame_reg <= pend_frame_reg;
            res_tlb_reg   <= 1'b0;
            res_tbl_reg   <= 1'b0;
            res_pf_reg    <= 1'b1;
        end
    end

    // Page-table frame store, read at request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            pt_data_reg <= pt_mem[in_page];
        end
        if (cmd.do_fault)
        begin
            pt_mem[page] <= free_frame_reg;
        end
    end

    // TLB tags and frames
    always_ff @(posedge clk)
    begin
        if (tlb_insert)
        begin
            tlb_tag_reg[tlb_ptr_reg]   <= page;
            tlb_frame_reg[tlb_ptr_reg] <= sel_frame;
        end
    end

    // Frame memory: fill writes and translation reads never share a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.fill_write)
        begin
            fm_mem[{pend_frame_reg, fill_pos_reg}] <= item_byte_reg;
        end
        if (fm_rd_en)
        begin
            fm_data_reg <= fm_mem[fm_rd_addr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg   <= '0;
            tlb_valid_reg  <= '0;
            tlb_ptr_reg    <= '0;
            free_frame_reg <= '0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            pending_reg    <= 1'b0;
            fill_pos_reg   <= '0;
            pend_addr_reg  <= '0;
            pend_frame_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (tlb_insert)
            begin
                tlb_valid_reg[tlb_ptr_reg] <= 1'b1;
                tlb_ptr_reg                <= tlb_ptr_reg + 1'b1;
            end
            if (cmd.do_hit && (hit_cnt_reg != {tlbpat_pkg::COUNT_W{1'b1}}))
            begin
                hit_cnt_reg <= hit_cnt_reg + 1'b1;
            end
            if (cmd.do_fault)
            begin
                pt_valid_reg[page] <= 1'b1;
                free_frame_reg     <= free_frame_reg + 1'b1;
                fault_cnt_reg      <= fault_cnt_next;
                pending_reg        <= 1'b1;
                fill_pos_reg       <= '0;
                pend_addr_reg      <= item_addr_reg;
                pend_frame_reg     <= free_frame_reg;
            end
            if (cmd.fill_write)
            begin
                // position wraps to zero after the last byte of the page
                fill_pos_reg <= fill_pos_reg + 1'b1;
                if (fill_last)
                begin
                    pending_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hits_reg   <= hit_cnt_reg;
            out_faults_reg <= cmd.do_fault ? fault_cnt_next : fault_cnt_reg;
            if (cmd.emit_value)
            begin
                out_kind_reg  <= tlbpat_pkg::KIND_VALUE;
                out_value_reg <= fm_data_reg;
                out_page_reg  <= res_page_reg;
                out_frame_reg <= res_frame_reg;
                out_tlb_reg   <= res_tlb_reg;
                out_tbl_reg   <= res_tbl_reg;
                out_pf_reg    <= res_pf_reg;
            end
            else if (cmd.do_fault)
            begin
                out_kind_reg  <= tlbpat_pkg::KIND_FILL;
                out_value_reg <= '0;
                out_page_reg  <= page;
                out_frame_reg <= free_frame_reg;
                out_tlb_reg   <= 1'b0;
                out_tbl_reg   <= 1'b0;
                out_pf_reg    <= 1'b1;
            end
            else
            begin
                out_kind_reg  <= tlbpat_pkg::KIND_ERROR;
                out_value_reg <= '0;
                out_page_reg  <= '0;
                out_frame_reg <= '0;
                out_tlb_reg   <= 1'b0;
                out_tbl_reg   <= 1'b0;
                out_pf_reg    <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {{tlbpat_pkg::OUT_PAD_W{1'b0}},
                            out_faults_reg, out_hits_reg,
                            out_pf_reg, out_tbl_reg, out_tlb_reg,
                            out_frame_reg, out_page_reg, out_value_reg};

endmodule

`default_nettype wire

// File: src/tlb_paged_address_translator.sv
// A request is taken in IDLE and looked up in LOOKUP. A TLB or page-table hit
// emits from READ after the frame-memory read, a final fill byte passes FILLRD
// and READ, and a fault or error result is loaded from LOOKUP. One request in
// flight; the next is taken back in IDLE, later while a result waits on tready.
// Reset (rst_n low, asynchronous) clears all page-table and TLB valid bits,
// the counters, the frame allocator and any pending fill at once.
`default_nettype none

module tlb_paged_address_translator (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Request stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [15:0] virtual address, [23:16] fill byte
    input  wire logic [tlbpat_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] op (0 translate, 1 fill byte)
    input  wire logic [tlbpat_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // Result stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [7:0] value, [15:8] page, [23:16] frame, [24] tlb_hit,
    // [25] table_hit, [26] page_fault, [42:27] tlb_hit_count,
    // [58:43] fault_count, [63:59] zero
    output logic [tlbpat_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // [1:0] kind (0 value, 1 fill request, 2 out-of-order request)
    output logic [tlbpat_pkg::OUT_USER_W-1:0]         m_axis_tuser
);

    tlbpat_pkg::dp_cmd_t    cmd;
    tlbpat_pkg::dp_status_t status;

    // Controller: takes one request, sequences lookup, fill and memory read,
    // and holds results back while the output register is occupied.
    tlbpat_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // Datapath: 16-entry FIFO-replaced TLB, 256-entry page table with valid
    // flops, 64 KiB frame memory, saturating counters and the result register.
    tlbpat_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

`default_nettype wire

// File: tb/sv/tlbpat_checker.sv
// Checker for the paged address translator: watches both streams, predicts
// each request's result from its own copy of the page table, TLB and frames.
// Depends on tlbpat_pkg for widths, opcodes and result kinds.
module tlbpat_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    input  wire logic                                 s_tready,
    // [15:0] virtual address, [23:16] fill byte
    input  wire logic [tlbpat_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] op
    input  wire logic [tlbpat_pkg::IN_USER_W-1:0]     s_tuser,
    input  wire logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    // [7:0] value, [15:8] page, [23:16] frame, [24] tlb_hit, [25] table_hit,
    // [26] page_fault, [42:27] hit count, [58:43] fault count, [63:59] zero
    input  wire logic [tlbpat_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [1:0] kind
    input  wire logic [tlbpat_pkg::OUT_USER_W-1:0]    m_tuser,
    output int                                        mismatches,
    output int                                        awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        tlbpat_pkg::kind_t kind;
        logic [7:0]        value;
        logic [7:0]        page;
        logic [7:0]        frame;
        logic              tlb_hit;
        logic              table_hit;
        logic              page_fault;
        logic [15:0]       hits;
        logic [15:0]       faults;
    } translation_t;

    translation_t awaited_translations [$];

    logic [255:0] pt_valid;
    logic [7:0]   pt_frame  [256];
    logic [15:0]  tlb_valid;
    logic [7:0]   tlb_page  [16];
    logic [7:0]   tlb_frame [16];
    logic [7:0]   frame_mem [65536];
    logic [3:0]   tlb_next;
    logic [7:0]   alloc_frame;
    logic [15:0]  hits;
    logic [15:0]  faults;
    logic         filling;
    logic [7:0]   fill_idx;
    logic [15:0]  miss_addr;
    logic [7:0]   miss_frame;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Overwrite the TLB slot under the FIFO pointer
    task automatic tlb_load(input logic [7:0] page, input logic [7:0] frame);
        tlb_valid[tlb_next] = 1'b1;
        tlb_page[tlb_next]  = page;
        tlb_frame[tlb_next] = frame;
        tlb_next++;
    endtask

    // Advance the translator state by one request and queue its result, if any
    task automatic translate_request(input logic op, input logic [15:0] addr,
                                     input logic [7:0] fbyte);
        translation_t r;
        logic [7:0]   page;
        logic [7:0]   frame;
        logic         found;
        logic         has_result;
        int           i;
        r = '0;
        r.kind = tlbpat_pkg::KIND_ERROR;
        has_result = 1'b1;
        page = addr[15:8];
        frame = '0;
        found = 1'b0;
        if (op == tlbpat_pkg::OP_TRANSLATE && !filling) begin
            for (i = 0; i < tlbpat_pkg::TLB_ENTRIES; i++) begin
                if (!found && tlb_valid[i] && tlb_page[i] == page) begin
                    found = 1'b1;
                    frame = tlb_frame[i];
                end
            end
            r.page = page;
            if (found) begin
                if (hits != 16'hFFFF)
                    hits++;
                r.kind = tlbpat_pkg::KIND_VALUE;
                r.value = frame_mem[{frame, addr[7:0]}];
                r.tlb_hit = 1'b1;
            end else if (pt_valid[page]) begin
                frame = pt_frame[page];
                tlb_load(page, frame);
                r.kind = tlbpat_pkg::KIND_VALUE;
                r.value = frame_mem[{frame, addr[7:0]}];
                r.table_hit = 1'b1;
            end else begin
                frame = alloc_frame;
                pt_valid[page] = 1'b1;
                pt_frame[page] = frame;
                tlb_load(page, frame);
                alloc_frame++;
                if (faults != 16'hFFFF)
                    faults++;
                filling = 1'b1;
                fill_idx = '0;
                miss_addr = addr;
                miss_frame = frame;
                r.kind = tlbpat_pkg::KIND_FILL;
                r.page_fault = 1'b1;
            end
            r.frame = frame;
        end else if (op == tlbpat_pkg::OP_FILL && filling) begin
            frame_mem[{miss_frame, fill_idx}] = fbyte;
            if (fill_idx != 8'hFF) begin
                fill_idx++;
                has_result = 1'b0;
            end else begin
                // Last byte of the page: answer the access that faulted
                filling = 1'b0;
                fill_idx = '0;
                r.kind = tlbpat_pkg::KIND_VALUE;
                r.value = frame_mem[{miss_frame, miss_addr[7:0]}];
                r.page = miss_addr[15:8];
                r.frame = miss_frame;
                r.page_fault = 1'b1;
            end
        end
        r.hits = hits;
        r.faults = faults;
        if (has_result)
            awaited_translations.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        translation_t want;
        if (!rst_n) begin
            pt_valid = '0;
            tlb_valid = '0;
            tlb_next = '0;
            alloc_frame = '0;
            hits = '0;
            faults = '0;
            filling = 1'b0;
            fill_idx = '0;
            miss_addr = '0;
            miss_frame = '0;
            awaited_translations.delete();
            mismatches = 0;
            awaited = 0;
        end else begin
            if (s_tvalid && s_tready)
                translate_request(s_tuser[0], s_tdata[15:0], s_tdata[23:16]);
            if (m_tvalid && m_tready) begin
                if (awaited_translations.size() == 0) begin
                    flag_mismatch("result with no request waiting for it");
                end else begin
                    want = awaited_translations.pop_front();
                    check_field("kind", {14'b0, m_tuser}, {14'b0, want.kind});
                    check_field("value", {8'b0, m_tdata[7:0]}, {8'b0, want.value});
                    check_field("page", {8'b0, m_tdata[15:8]}, {8'b0, want.page});
                    check_field("frame", {8'b0, m_tdata[23:16]}, {8'b0, want.frame});
                    check_field("tlb_hit", {15'b0, m_tdata[24]}, {15'b0, want.tlb_hit});
                    check_field("table_hit", {15'b0, m_tdata[25]},
                                {15'b0, want.table_hit});
                    check_field("page_fault", {15'b0, m_tdata[26]},
                                {15'b0, want.page_fault});
                    check_field("tlb_hit_count", m_tdata[42:27], want.hits);
                    check_field("fault_count", m_tdata[58:43], want.faults);
                    check_field("padding", {11'b0, m_tdata[63:59]}, 16'h0000);
                end
            end
            awaited = awaited_translations.size();
        end
    end

endmodule

// File: tb/sv/tlb_paged_address_translator_tb.sv
// Top of the translator testbench: clock, reset, request and result stream
// drivers, and the verdict. Depends on tlbpat_pkg, tlbpat_checker and the RTL.
module tlb_paged_address_translator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    // [15:0] virtual address, [23:16] fill byte
    logic [tlbpat_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;
    // [0] op (0 translate, 1 fill byte)
    logic [tlbpat_pkg::IN_USER_W-1:0]      s_axis_tuser = '0;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    // [7:0] value, [15:8] page, [23:16] frame, [24] tlb_hit,
    // [25] table_hit, [26] page_fault, [42:27] tlb_hit_count,
    // [58:43] fault_count, [63:59] zero
    logic [tlbpat_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
    // [1:0] kind
    logic [tlbpat_pkg::OUT_USER_W-1:0]     m_axis_tuser;

    int mismatches;
    int awaited;

    // Idle chances in percent; zero turns idling off on that side
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;

    // Pages the stimulus has already faulted in; table entries never go
    // invalid, so a translate to any other page is a fault
    bit         mapped [256];
    logic [7:0] recent_pages [32];
    logic [4:0] recent_wr = '0;
    int         recent_cnt = 0;

    tlb_paged_address_translator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tlbpat_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tuser    (s_axis_tuser),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Result side: now and then hold tready low for a random burst
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready = 1'b0;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            m_axis_tready = 1'b0;
            stall_left = $urandom_range(5);
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // Present one request at the falling edge, optionally after a gap, and
    // hold it until the rising edge at which the block takes it
    task automatic push_request(input logic op, input logic [15:0] addr,
                                input logic [7:0] fbyte);
        int gap;
        @(negedge clk);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {fbyte, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Supply a whole page of fill bytes; now and then slip in a translate,
    // which the block must reject while the fill is open
    task automatic fill_page();
        int n;
        for (n = 0; n < 256; n++) begin
            if ($urandom_range(99) < 3)
                push_request(tlbpat_pkg::OP_TRANSLATE, 16'($urandom), 8'($urandom));
            push_request(tlbpat_pkg::OP_FILL, 16'($urandom), 8'($urandom));
        end
    endtask

    // Translate one address; a first touch of a page faults, so follow it
    // with the fill the block asks for
    task automatic access_page(input logic [7:0] page, input logic [7:0] offset);
        push_request(tlbpat_pkg::OP_TRANSLATE, {page, offset}, 8'($urandom));
        if (!mapped[page]) begin
            mapped[page] = 1'b1;
            fill_page();
        end
        recent_pages[recent_wr] = page;
        recent_wr++;
        if (recent_cnt < 32)
            recent_cnt++;
    endtask

    // Revisit a mapped page at a random or edge offset, or now and then
    // send a stray fill byte that the block must reject
    task automatic random_request();
        logic [7:0] page;
        logic [7:0] offset;
        if ($urandom_range(99) < 8)
        begin
            push_request(tlbpat_pkg::OP_FILL, 16'($urandom), 8'($urandom));
        end
        else
        begin
            page = recent_pages[5'($urandom_range(recent_cnt - 1))];
            if ($urandom_range(4) == 0)
                offset = $urandom_range(1) ? 8'hFF : 8'h00;
            else
                offset = 8'($urandom);
            access_page(page, offset);
        end
    endtask

    initial
    begin
        int count;
        int drain;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, light idling on both sides
        gap_pct = 20;
        stall_pct = 20;
        // Fill byte with no fill open
        push_request(tlbpat_pkg::OP_FILL, 16'hFFFF, 8'hFF);
        // Fault on the lowest page, then a TLB hit at the top offset
        access_page(8'h00, 8'h00);
        access_page(8'h00, 8'hFF);
        // Same for the highest page
        access_page(8'hFF, 8'hFF);
        access_page(8'hFF, 8'h00);
        // One more fault on a page in between
        access_page(8'($urandom_range(1, 254)), 8'($urandom));

        // Random part: idling changes every 16 requests
        for (count = 0; count < 40; count++)
        begin
            if (count % 16 == 0)
            begin
                gap_pct = $urandom_range(10, 35);
                stall_pct = $urandom_range(10, 35);
            end
            random_request();
        end

        // Last part, no idling
        gap_pct = 0;
        stall_pct = 0;
        stall_left = 0;
        for (count = 0; count < 24; count++)
            random_request();

        @(negedge clk);
        s_axis_tvalid = 1'b0;

        // Drain outstanding results, then watch a little longer for strays
        drain = 0;
        while (awaited != 0 && drain < 5000) begin
            @(negedge clk);
            drain++;
        end
        repeat (16) @(negedge clk);

        if (mismatches == 0 && awaited == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
